// ===== sv/pmc_pkg.sv =====
// Shared types, constants and coefficient lookup for the piecewise MVA cut classifier.
// No dependencies; every other file refers to this package by scoped names.

package pmc_pkg;

	// Field widths of one candidate
	localparam int WP_W    = 4;
	localparam int SCORE_W = 15;
	localparam int MOM_W   = 16;
	localparam int RAP_W   = 12;

	// Working points and curve split
	localparam int WP_COUNT    = 9;
	localparam int CURVE_SPLIT = 6;

	// Threshold numerator is held over 1920 * 1000
	localparam int DEN = 1920;

	// Threshold numerator, slope and intermediate widths
	localparam int NUM_W   = 25;
	localparam int SLOPE_W = 17;
	localparam int DIFF_W  = MOM_W + 1;
	localparam int PROD_W  = SLOPE_W + DIFF_W;
	localparam int SUM_W   = PROD_W + 1;
	localparam int CMP_W   = 27;

	// Score scale: s * 15000 > n * 8 is the same as s * 1875 > n
	localparam int SCORE_MUL = 1875;

	// Momentum break points in 1/64 units
	localparam int MOM_LO      = 640;
	localparam int MOM_HI      = 1600;
	localparam int LIN_OFFSET  = 640;
	localparam int CLMP_OFFSET = 960;
	localparam int LIN_SLOPE   = 2;
	localparam int CLMP_SLOPE  = 3;

	// Rapidity bin edges in 1/1024 units
	localparam int RAP_BIN0_MAX = 819;
	localparam int RAP_BIN2_MIN = 1515;

	localparam logic [1:0] BIN_BARREL  = 2'd0;
	localparam logic [1:0] BIN_OVERLAP = 2'd1;
	localparam logic [1:0] BIN_ENDCAP  = 2'd2;

	// Coefficients (A, B, C) in thousandths, per working point and rapidity bin
	localparam int COEF_TABLE [WP_COUNT][3][3] = '{
		'{ '{  214,  1204,  1320 }, '{  -411,    84,   192 }, '{  -918,  -123,   362 } },
		'{ '{-1036,  -106,    53 }, '{ -1339,  -769,  -434 }, '{ -2091, -1461,  -956 } },
		'{ '{ 2597,  4277,  2597 }, '{  2252,  3152,  2252 }, '{  1054,  2359,  1054 } },
		'{ '{ -788,  -640,   488 }, '{  -850,  -775,   -45 }, '{  -810,  -733,   176 } },
		'{ '{ -930,  -887,  -135 }, '{  -930,  -890,  -417 }, '{  -942,  -910,  -470 } },
		'{ '{  200,   680,   200 }, '{   100,   475,   100 }, '{  -100,   320,  -100 } },
		'{ '{ -480,  -850,  -460 }, '{  -670,  -910,   -30 }, '{  -490,  -830,   -10 } },
		'{ '{ -860,  -960,  -300 }, '{  -850,  -960,  -360 }, '{  -810,  -950,  -630 } },
		'{ '{  770,   520,   770 }, '{   560,   110,   560 }, '{   480,   -10,   480 } }
	};

	// One candidate as carried through the pipeline
	typedef struct packed {
		logic [WP_W-1:0]           working_point;
		logic signed [SCORE_W-1:0] discriminant;
		logic [MOM_W-1:0]          momentum;
		logic [RAP_W-1:0]          abs_rapidity;
	} item_t;

	// Scaled coefficients for one table entry
	typedef struct packed {
		logic signed [NUM_W-1:0]   a;
		logic signed [NUM_W-1:0]   b;
		logic signed [NUM_W-1:0]   c;
		logic signed [SLOPE_W-1:0] slope;
	} coef_t;

	// Look up an entry and scale it to the 1920 denominator; wp is already saturated
	function automatic coef_t coef_lookup(input logic [WP_W-1:0] wp, input logic [1:0] bin);
		coef_t k;
		int    ca;
		int    cb;
		int    cc;
		int    mul;
		ca  = COEF_TABLE[wp][bin][0];
		cb  = COEF_TABLE[wp][bin][1];
		cc  = COEF_TABLE[wp][bin][2];
		mul = (int'(wp) < CURVE_SPLIT) ? LIN_SLOPE : CLMP_SLOPE;
		k.a     = NUM_W'(ca * DEN);
		k.b     = NUM_W'(cb * DEN);
		k.c     = NUM_W'(cc * DEN);
		k.slope = SLOPE_W'(mul * (cb - ca));
		return k;
	endfunction

endpackage

// ===== sv/pmc_channels.sv =====
// Handshake channels of the piecewise MVA cut classifier: candidate in, verdict out.
// Depends on pmc_pkg for field widths.

interface pmc_item_if;
	logic                               valid;
	logic                               ready;
	logic [pmc_pkg::WP_W-1:0]           working_point;
	logic signed [pmc_pkg::SCORE_W-1:0] discriminant;
	logic [pmc_pkg::MOM_W-1:0]          momentum;
	logic [pmc_pkg::RAP_W-1:0]          abs_rapidity;

	modport source (output valid, working_point, discriminant, momentum, abs_rapidity,
		input ready);
	modport sink (input valid, working_point, discriminant, momentum, abs_rapidity,
		output ready);
endinterface

interface pmc_result_if;
	logic valid;
	logic ready;
	logic pass;

	modport source (output valid, pass, input ready);
	modport sink (input valid, pass, output ready);
endinterface

// ===== sv/pmc_threshold.sv =====
// Threshold evaluation for one candidate: bin, coefficient lookup, curve and compare.
// Purely combinational; depends on pmc_pkg.

module pmc_threshold (
	input  pmc_pkg::item_t item,
	output logic           pass
);

	logic [pmc_pkg::WP_W-1:0]           wp;
	logic [1:0]                         bin;
	logic                               clamped;
	pmc_pkg::coef_t                     k;
	logic signed [pmc_pkg::DIFF_W-1:0]  diff;
	logic signed [pmc_pkg::PROD_W-1:0]  prod;
	logic signed [pmc_pkg::SUM_W-1:0]   ramp;
	logic signed [pmc_pkg::NUM_W-1:0]   num;
	logic signed [pmc_pkg::CMP_W-1:0]   lhs;
	logic signed [pmc_pkg::CMP_W-1:0]   rhs;

	// Saturate the working point and pick the curve style
	always_comb begin
		if (item.working_point >= pmc_pkg::WP_W'(pmc_pkg::WP_COUNT)) begin
			wp = pmc_pkg::WP_W'(pmc_pkg::WP_COUNT - 1);
		end else begin
			wp = item.working_point;
		end
		clamped = (wp >= pmc_pkg::WP_W'(pmc_pkg::CURVE_SPLIT));
	end

	// Rapidity bin
	always_comb begin
		if (item.abs_rapidity <= pmc_pkg::RAP_W'(pmc_pkg::RAP_BIN0_MAX)) begin
			bin = pmc_pkg::BIN_BARREL;
		end else if (item.abs_rapidity >= pmc_pkg::RAP_W'(pmc_pkg::RAP_BIN2_MIN)) begin
			bin = pmc_pkg::BIN_ENDCAP;
		end else begin
			bin = pmc_pkg::BIN_OVERLAP;
		end
	end

	assign k = pmc_pkg::coef_lookup(wp, bin);

	// Ramp A + slope * (m - offset), offset depending on curve style
	always_comb begin
		if (clamped) begin
			diff = $signed({1'b0, item.momentum}) - pmc_pkg::DIFF_W'(pmc_pkg::CLMP_OFFSET);
		end else begin
			diff = $signed({1'b0, item.momentum}) - pmc_pkg::DIFF_W'(pmc_pkg::LIN_OFFSET);
		end
		prod = pmc_pkg::PROD_W'(k.slope) * pmc_pkg::PROD_W'(diff);
		ramp = pmc_pkg::SUM_W'(k.a) + pmc_pkg::SUM_W'(prod);
	end

	// Select the threshold numerator
	always_comb begin
		if (!clamped) begin
			if (item.momentum < pmc_pkg::MOM_W'(pmc_pkg::MOM_LO)) begin
				num = k.c;
			end else if (item.momentum > pmc_pkg::MOM_W'(pmc_pkg::MOM_HI)) begin
				num = k.b;
			end else begin
				// ramp stays between A and B here
				num = ramp[pmc_pkg::NUM_W-1:0];
			end
		end else begin
			if (item.momentum <= pmc_pkg::MOM_W'(pmc_pkg::MOM_LO)) begin
				num = k.c;
			end else if (ramp < pmc_pkg::SUM_W'(k.b)) begin
				// floor at B first, then cap at A
				num = (k.b > k.a) ? k.a : k.b;
			end else if (ramp > pmc_pkg::SUM_W'(k.a)) begin
				num = k.a;
			end else begin
				num = ramp[pmc_pkg::NUM_W-1:0];
			end
		end
	end

	// Strict compare of the scaled score against the numerator
	always_comb begin
		lhs  = pmc_pkg::CMP_W'(item.discriminant) * pmc_pkg::CMP_W'(pmc_pkg::SCORE_MUL);
		rhs  = pmc_pkg::CMP_W'(num);
		pass = (lhs > rhs);
	end

endmodule

// ===== sv/piecewise_mva_cut_classifier.sv =====
// Top level of the piecewise MVA cut classifier: input register, threshold logic, result register.
// Depends on pmc_pkg, pmc_channels (pmc_item_if, pmc_result_if) and pmc_threshold.
//
// Usage:
//   item   - candidate transactions (working point, score, momentum, rapidity) in.
//   result - one verdict transaction (pass) out for every candidate, in order.
//   A candidate is captured in the input register when item accepts it, and its
//   verdict is registered in the result register once that stage advances.
//   Throughput is one candidate per cycle while result is not stalled; the
//   threshold logic between the input register and the result register is a
//   single pass of a table lookup, one slope multiply, a clamp and one compare.
//   The result register acts as the output stage: a new candidate is taken
//   while a finished verdict waits, and the two stages hold their contents
//   while result is stalled. item.ready drops only when both stages are full
//   and result.ready is low.
//   Reset clears both stage valid flags; nothing is pending afterwards and
//   item.ready is high from the first cycle out of reset.

module piecewise_mva_cut_classifier (
	input  logic                clk,
	input  logic                arst_n,
	pmc_item_if.sink            item,
	pmc_result_if.source        result
);

	logic           valid_s1;
	pmc_pkg::item_t item_s1;
	logic           valid_q;
	logic           pass_q;
	logic           pass_comb;
	logic           advance;
	logic           accept;

	// Stage moves on when the result register is empty or being drained
	assign advance    = !valid_q || result.ready;
	assign item.ready = !valid_s1 || advance;
	assign accept     = item.valid && item.ready;

	// Input register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	// Input register: payload
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.working_point <= item.working_point;
			item_s1.discriminant  <= item.discriminant;
			item_s1.momentum      <= item.momentum;
			item_s1.abs_rapidity  <= item.abs_rapidity;
		end
	end

	pmc_threshold u_threshold (
		.item (item_s1),
		.pass (pass_comb)
	);

	// Result register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= valid_s1;
		end
	end

	// Result register: verdict
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			pass_q <= pass_comb;
		end
	end

	assign result.valid = valid_q;
	assign result.pass  = pass_q;

	// An accepted transaction occupies the input register next cycle
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted candidate did not reach the input register");

	// A stage-1 candidate that advances lands in the result register with its verdict
	a_s1_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance |=> valid_q && (pass_q == $past(pass_comb)))
		else $error("verdict lost between input and result register");

	// An empty input register never blocks the input channel
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> item.ready)
		else $error("input stalled while the input register is empty");

endmodule
